@@ hw/rtl/rkdc_pkg.sv @@
package rkdc_pkg;

    localparam int RECORD_BYTES = 32;
    localparam int POS_W        = 5;
    localparam int NAME_START   = 16;
    localparam logic [7:0]  NAME_LIMIT = 8'd128;
    localparam logic [15:0] KEY_POLY   = 16'h1021;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // configuration register indexes
    localparam logic CFG_BASE_KEY    = 1'b0;
    localparam logic CFG_ADDRESS_MIX = 1'b1;

    // one decrypted byte handed from front to back
    typedef struct packed {
        logic [7:0]       plain;
        logic [POS_W-1:0] pos;
    } entry_t;

    function automatic logic [15:0] lfsr_next(input logic [15:0] k);
        logic [15:0] n;
        n = {k[14:0], 1'b0};
        if (k[15])
        begin
            n = n ^ KEY_POLY;
        end
        return n;
    endfunction

    // CRC-16, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (r[15])
            begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/rkdc_front.sv @@
module rkdc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_wdata,
    input  logic                 in_valid,
    input  logic [7:0]           enc_byte,
    input  logic [31:0]          byte_addr,
    input  logic                 push_ok,
    output logic                 push,
    output rkdc_pkg::entry_t     push_entry
);

    logic [15:0] base_key_reg;
    logic        address_mix_reg;
    logic [15:0] key_reg;
    logic [15:0] key_next;
    logic [15:0] seed;
    logic [15:0] key_used;
    logic [rkdc_pkg::POS_W-1:0] pos;

    assign pos  = byte_addr[rkdc_pkg::POS_W-1:0];
    assign push = in_valid && push_ok;

    // record address >> 2, low 16 bits
    always_comb
    begin
        seed = base_key_reg;
        if (address_mix_reg)
        begin
            seed = base_key_reg ^ {byte_addr[17:5], 3'b000};
        end
        key_used = (pos == '0) ? seed : key_reg;
        key_next = rkdc_pkg::lfsr_next(key_used);
    end

    assign push_entry.plain = enc_byte ^ key_used[7:0];
    assign push_entry.pos   = pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_key_reg    <= '0;
            address_mix_reg <= 1'b0;
            key_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rkdc_pkg::CFG_BASE_KEY:    base_key_reg    <= cfg_wdata;
                    rkdc_pkg::CFG_ADDRESS_MIX: address_mix_reg <= cfg_wdata[0];
                endcase
            end
            if (push)
            begin
                key_reg <= key_next;
            end
        end
    end

endmodule

@@ hw/rtl/rkdc_queue.sv @@
module rkdc_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rkdc_pkg::entry_t push_entry,
    output logic             push_ok,
    input  logic             pop,
    output logic             head_valid,
    output rkdc_pkg::entry_t head
);

    localparam int CNT_W = rkdc_pkg::QPTR_W + 1;

    rkdc_pkg::entry_t                mem_reg [rkdc_pkg::QUEUE_DEPTH];
    logic [rkdc_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [rkdc_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]                count_reg;

    assign push_ok    = (count_reg != CNT_W'(rkdc_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/rkdc_back.sv @@
module rkdc_back
#(
    parameter int NAME_BYTES = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  rkdc_pkg::entry_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       plain_byte,
    output logic             record_last,
    output logic             record_valid
);

    typedef enum logic [1:0]
    {
        NS_SEARCHING,
        NS_FOUND,
        NS_FAILED
    } name_state_t;

    localparam logic [5:0] NAME_LO = 6'(rkdc_pkg::NAME_START);
    localparam logic [5:0] NAME_HI = 6'(rkdc_pkg::NAME_START + NAME_BYTES);
    localparam logic [rkdc_pkg::POS_W-1:0] POS_LAST =
        rkdc_pkg::POS_W'(rkdc_pkg::RECORD_BYTES - 1);

    logic [15:0] crc_reg, crc_next;
    logic [15:0] stored_reg, stored_next;
    name_state_t ns_reg, ns_next;
    logic        out_valid_reg;
    logic [7:0]  plain_reg;
    logic        last_reg, last_next;
    logic        valid_reg, valid_next;
    logic [5:0]  pos_ext;
    logic        first;

    assign pop          = head_valid && (!out_valid_reg || out_ready);
    assign out_valid    = out_valid_reg;
    assign plain_byte   = plain_reg;
    assign record_last  = last_reg;
    assign record_valid = valid_reg;

    assign pos_ext = {1'b0, head.pos};
    assign first   = (head.pos == '0);

    always_comb
    begin
        crc_next    = first ? 16'h0000 : crc_reg;
        stored_next = first ? 16'h0000 : stored_reg;
        ns_next     = first ? NS_SEARCHING : ns_reg;

        if (head.pos == rkdc_pkg::POS_W'(0))
        begin
            stored_next = {stored_next[15:8], head.plain};
        end
        else if (head.pos == rkdc_pkg::POS_W'(1))
        begin
            stored_next = {head.plain, stored_next[7:0]};
        end
        else
        begin
            crc_next = rkdc_pkg::crc_byte(crc_next, head.plain);
        end

        // zero must show up before any byte above the limit
        if (pos_ext >= NAME_LO && pos_ext < NAME_HI && ns_next == NS_SEARCHING)
        begin
            priority if (head.plain > rkdc_pkg::NAME_LIMIT)
            begin
                ns_next = NS_FAILED;
            end
            else if (head.plain == 8'h00)
            begin
                ns_next = NS_FOUND;
            end
            else
            begin
                ns_next = NS_SEARCHING;
            end
        end

        last_next  = (head.pos == POS_LAST);
        valid_next = last_next && (crc_next == stored_next) && (ns_next == NS_FOUND);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '0;
            stored_reg    <= '0;
            ns_reg        <= NS_SEARCHING;
            out_valid_reg <= 1'b0;
            plain_reg     <= '0;
            last_reg      <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                crc_reg       <= crc_next;
                stored_reg    <= stored_next;
                ns_reg        <= ns_next;
                out_valid_reg <= 1'b1;
                plain_reg     <= head.plain;
                last_reg      <= last_next;
                valid_reg     <= valid_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ hw/rtl/record_keystream_decrypt_check.sv @@
// Keystream decryptor and entry checker for 32-byte flash records. Feed one
// encrypted byte per item with its flash byte offset; the low five offset bits
// are the position in the record and bytes of a record must come in order.
// Position 0 reloads the 16-bit key from base_key (XOR record address >> 2
// when address_mix is set); each byte is XORed with the low key byte and the
// key then steps as a shift register with feedback 0x1021. Every input item
// gives one output item. On position 31 tlast is set and tuser reports
// whether the record is a valid entry: CRC-16 (0x1021, init 0, MSB first)
// over plain bytes 2..31 equals bytes 0..1 little-endian, and a zero byte
// appears among the name bytes before any byte above 128. Throughput is one
// item per cycle while the output is not stalled. Each item is decrypted on
// the input side into a 4-entry queue, then passes the check stage and is
// held in its output register before it leaves the block.
// With the output stalled, the queue and output register hold five items
// before s_tready drops. Write configuration only while the block is empty.
module record_keystream_decrypt_check
#(
    parameter int NAME_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration: index 0 base_key, index 1 address_mix
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] enc_byte, [39:8] byte_addr

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] plain_byte
    output logic        m_tlast,   // record_last
    output logic        m_tuser    // record_valid
);

    logic             push;
    logic             push_ok;
    rkdc_pkg::entry_t push_entry;
    logic             pop;
    logic             head_valid;
    rkdc_pkg::entry_t head;

    assign s_tready = push_ok;

    // front: key stream and decrypt, runs at input rate
    rkdc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .enc_byte   (s_tdata[7:0]),
        .byte_addr  (s_tdata[39:8]),
        .push_ok    (push_ok),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouples input side from output stalls
    rkdc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ok    (push_ok),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // back: CRC and name checks, output register
    rkdc_back
    #(
        .NAME_BYTES (NAME_BYTES)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .plain_byte   (m_tdata),
        .record_last  (m_tlast),
        .record_valid (m_tuser)
    );

endmodule
